FILE: hw/rtl/pmfb_pkg.sv
// pmfb_pkg: shared types and constants for the paged framebuffer plotter
// holds opcodes, byte patterns and the store request word; no dependencies
package pmfb_pkg;

  typedef enum logic [1:0] {
    OP_PLOT  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_FILL  = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  localparam int unsigned ROWS_PER_PAGE = 8;
  localparam logic [7:0]  BYTE_CLEAR    = 8'h00;
  localparam logic [7:0]  BYTE_FILL     = 8'hFF;
  localparam int unsigned STORE_ADDR_W  = 12;

  typedef struct packed {
    logic                    we;
    logic                    re;
    logic [STORE_ADDR_W-1:0] addr;
    logic [7:0]              wdata;
  } store_req_t;

endpackage

FILE: hw/rtl/pmfb_store.sv
// pmfb_store: single-port byte memory with registered read data
// depends on pmfb_pkg for the request word
module pmfb_store
  import pmfb_pkg::*;
#(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = 10
) (
  input  logic       clk,
  input  store_req_t req,
  output logic [7:0] rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;
  logic [ADDR_W-1:0] addr;

  assign addr  = req.addr[ADDR_W-1:0];
  assign rdata = rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[addr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[addr];
    end
  end

endmodule

FILE: hw/rtl/paged_mono_framebuffer_plotter.sv
// paged_mono_framebuffer_plotter: page-organized monochrome framebuffer
// depends on pmfb_pkg and pmfb_store
//
// usage
//   one input channel (in_valid / in_stall) takes a command word: plot a
//   scaled square, clear all, fill all, or read one byte by linear index
//   a read returns one word on the output channel (out_valid / out_stall)
//   plot, clear and fill return nothing
// sequence
//   read: the store is read in ST_RRD; in ST_RDAT the byte is loaded into
//   the output register once the slot is free, then a command can be taken
//   plot: setup in ST_MUL and ST_BOUND, then one read (ST_PRD) and one
//   write-back (ST_PWR) per byte touched on the single memory port; back to
//   idle after ST_BOUND when nothing lands on the panel, and s*p bytes for an
//   unclipped square of scale s over p pages (p is ceil(s/8) or one more)
//   clear and fill: one byte per cycle after the accept cycle,
//   PANEL_WIDTH*ceil(PANEL_HEIGHT/8) bytes (1024 by default)
// reset
//   the store is swept to zero one byte per cycle after reset, 1024 bytes
//   by default, with in_stall held high
// stall
//   a read result sits in the output register while out_stall is high; the
//   block keeps taking commands, and a second read waits for the slot
module paged_mono_framebuffer_plotter
  import pmfb_pkg::*;
#(
  parameter int unsigned PANEL_WIDTH  = 128,
  parameter int unsigned PANEL_HEIGHT = 64,
  parameter int unsigned MAX_SCALE    = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_operation,
  input  logic signed [8:0] in_x,
  input  logic signed [8:0] in_y,
  input  logic              in_color,
  input  logic [4:0]        in_scale,
  input  logic [9:0]        in_read_index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_read_data
);

  localparam int unsigned PAGE_COUNT  = (PANEL_HEIGHT + ROWS_PER_PAGE - 1) / ROWS_PER_PAGE;
  localparam int unsigned STORE_BYTES = PANEL_WIDTH * PAGE_COUNT;
  localparam int unsigned ADDR_W      = $clog2(STORE_BYTES);
  localparam int unsigned XW          = $clog2(PANEL_WIDTH);
  localparam int unsigned YW          = $clog2(PANEL_HEIGHT) + 1;
  localparam int unsigned PGW         = YW - 3;
  localparam int unsigned SW          = $clog2(MAX_SCALE + 1);
  localparam int unsigned CW          = 18;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_MUL,
    ST_BOUND,
    ST_PRD,
    ST_PWR,
    ST_RRD,
    ST_RDAT
  } state_t;

  state_t            state_r;
  logic [ADDR_W-1:0] addr_r;
  logic [ADDR_W-1:0] base_r;
  logic [7:0]        fill_r;
  logic              out_valid_r;
  logic [7:0]        out_data_r;

  logic                 color_r;
  logic [SW-1:0]        s_r;
  logic signed [8:0]    x_r;
  logic signed [8:0]    y_r;
  logic [ADDR_W-1:0]    ri_addr_r;
  logic                 ri_ok_r;
  logic signed [CW-1:0] x0_r;
  logic signed [CW-1:0] y0_r;
  logic [XW-1:0]        xlo_r;
  logic [XW-1:0]        xhi_r;
  logic [XW-1:0]        cx_r;
  logic [YW-1:0]        ylo_r;
  logic [YW-1:0]        yhi_r;
  logic [PGW-1:0]       pg_r;

  store_req_t req;
  logic [7:0] rdata;

  pmfb_store #(
    .DEPTH  (STORE_BYTES),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  // scale saturation and read index decode
  logic          sat;
  logic [SW-1:0] s_in;
  logic [12:0]   ri_ext;
  assign sat    = {3'b000, in_scale} > 8'(MAX_SCALE);
  assign s_in   = sat ? SW'(MAX_SCALE) : SW'(in_scale);
  assign ri_ext = {3'b000, in_read_index};

  // clipping
  logic signed [CW-1:0] s_ext;
  logic signed [CW-1:0] xe;
  logic signed [CW-1:0] ye;
  logic signed [CW-1:0] w_last;
  logic signed [CW-1:0] h_last;
  logic                 empty;
  logic [XW-1:0]        xlo_nxt;
  logic [XW-1:0]        xhi_nxt;
  logic [YW-1:0]        ylo_nxt;
  logic [YW-1:0]        yhi_nxt;
  logic [PGW-1:0]       pglo_nxt;
  logic [ADDR_W-1:0]    base_nxt;

  assign s_ext    = $signed(CW'(s_r));
  assign xe       = x0_r + s_ext - CW'(1);
  assign ye       = y0_r + s_ext - CW'(1);
  assign w_last   = $signed(CW'(PANEL_WIDTH - 1));
  assign h_last   = $signed(CW'(PANEL_HEIGHT - 1));
  assign empty    = (s_r == '0) || (xe < 0) || (ye < 0) || (x0_r > w_last) || (y0_r > h_last);
  assign xlo_nxt  = (x0_r < 0) ? '0 : XW'(x0_r);
  assign xhi_nxt  = (xe > w_last) ? XW'(PANEL_WIDTH - 1) : XW'(xe);
  assign ylo_nxt  = (y0_r < 0) ? '0 : YW'(y0_r);
  assign yhi_nxt  = (ye > h_last) ? YW'(PANEL_HEIGHT - 1) : YW'(ye);
  assign pglo_nxt = ylo_nxt[YW-1:3];
  assign base_nxt = ADDR_W'(32'(pglo_nxt) * PANEL_WIDTH);

  // row mask within the current page
  logic [2:0] lo_bit;
  logic [2:0] hi_bit;
  logic [7:0] mask;
  logic [7:0] merged;
  assign lo_bit = (pg_r == ylo_r[YW-1:3]) ? ylo_r[2:0] : 3'd0;
  assign hi_bit = (pg_r == yhi_r[YW-1:3]) ? yhi_r[2:0] : 3'd7;
  assign mask   = (8'hFF << lo_bit) & (8'hFF >> (3'd7 - hi_bit));
  assign merged = color_r ? (rdata | mask) : (rdata & ~mask);

  logic in_acc;
  logic out_free;
  assign in_acc   = in_valid && (state_r == ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    req       = '0;
    req.addr  = STORE_ADDR_W'(addr_r);
    req.wdata = fill_r;
    unique case (state_r)
      ST_SWEEP: req.we = 1'b1;
      ST_PRD:   req.re = 1'b1;
      ST_PWR: begin
        req.we    = 1'b1;
        req.wdata = merged;
      end
      ST_RRD: begin
        req.re   = 1'b1;
        req.addr = STORE_ADDR_W'(ri_addr_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      addr_r      <= '0;
      fill_r      <= BYTE_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == ST_RDAT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_SWEEP: begin
          addr_r <= addr_r + ADDR_W'(1);
          if (addr_r == ADDR_W'(STORE_BYTES - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            color_r   <= in_color;
            s_r       <= s_in;
            x_r       <= in_x;
            y_r       <= in_y;
            ri_addr_r <= ri_ext[ADDR_W-1:0];
            ri_ok_r   <= ri_ext < 13'(STORE_BYTES);
            unique case (op_t'(in_operation))
              OP_PLOT:  state_r <= ST_MUL;
              OP_CLEAR: begin
                addr_r  <= '0;
                fill_r  <= BYTE_CLEAR;
                state_r <= ST_SWEEP;
              end
              OP_FILL: begin
                addr_r  <= '0;
                fill_r  <= BYTE_FILL;
                state_r <= ST_SWEEP;
              end
              OP_READ:  state_r <= ST_RRD;
            endcase
          end
        end
        ST_MUL: begin
          x0_r    <= CW'(x_r) * $signed(CW'(s_r));
          y0_r    <= CW'(y_r) * $signed(CW'(s_r));
          state_r <= ST_BOUND;
        end
        ST_BOUND: begin
          xlo_r  <= xlo_nxt;
          xhi_r  <= xhi_nxt;
          cx_r   <= xlo_nxt;
          ylo_r  <= ylo_nxt;
          yhi_r  <= yhi_nxt;
          pg_r   <= pglo_nxt;
          base_r <= base_nxt;
          addr_r <= base_nxt + ADDR_W'(xlo_nxt);
          state_r <= empty ? ST_IDLE : ST_PRD;
        end
        ST_PRD: state_r <= ST_PWR;
        ST_PWR: begin
          state_r <= ST_PRD;
          if (cx_r == xhi_r) begin
            if (pg_r == yhi_r[YW-1:3]) begin
              state_r <= ST_IDLE;
            end else begin
              pg_r   <= pg_r + PGW'(1);
              base_r <= base_r + ADDR_W'(PANEL_WIDTH);
              addr_r <= base_r + ADDR_W'(PANEL_WIDTH) + ADDR_W'(xlo_r);
              cx_r   <= xlo_r;
            end
          end else begin
            cx_r   <= cx_r + XW'(1);
            addr_r <= addr_r + ADDR_W'(1);
          end
        end
        ST_RRD: state_r <= ST_RDAT;
        ST_RDAT: begin
          if (out_free) begin
            out_data_r <= ri_ok_r ? rdata : BYTE_CLEAR;
            state_r    <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall      = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

endmodule

FILE: dv/pmfb_checker.sv
`timescale 1ns / 1ps
// pmfb_checker: mirrors the plotter's pixel store from accepted command words
// and compares every returned byte; depends on pmfb_pkg
module pmfb_checker
  import pmfb_pkg::*;
#(
  parameter int unsigned PANEL_WIDTH  = 128,
  parameter int unsigned PANEL_HEIGHT = 64,
  parameter int unsigned MAX_SCALE    = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [1:0]        in_operation,
  input  logic signed [8:0] in_x,
  input  logic signed [8:0] in_y,
  input  logic              in_color,
  input  logic [4:0]        in_scale,
  input  logic [9:0]        in_read_index,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [7:0]        out_read_data,
  output int                fail_count,
  output int                pending
);

  localparam int unsigned PAGES       = (PANEL_HEIGHT + ROWS_PER_PAGE - 1) / ROWS_PER_PAGE;
  localparam int unsigned STORE_BYTES = PANEL_WIDTH * PAGES;

  logic [7:0] shadow_pixels [STORE_BYTES];
  logic [7:0] pending_bytes [$];

  function automatic void paint_square(int col, int row, int side, bit on);
    int px;
    int py;
    int idx;
    for (int k = 0; k < side; k++) begin
      for (int l = 0; l < side; l++) begin
        px = side * col + k;
        py = side * row + l;
        if (px >= 0 && px < int'(PANEL_WIDTH) && py >= 0 && py < int'(PANEL_HEIGHT)) begin
          idx = px + (py / int'(ROWS_PER_PAGE)) * int'(PANEL_WIDTH);
          shadow_pixels[idx][py % int'(ROWS_PER_PAGE)] = on;
        end
      end
    end
  endfunction

  always @(posedge clk) begin
    logic [7:0] want;
    int side;
    if (!rst_n) begin
      foreach (shadow_pixels[i]) shadow_pixels[i] = BYTE_CLEAR;
      pending_bytes.delete();
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_bytes.size() == 0) begin
          $error("read_data word with no read pending: actual %02h", out_read_data);
          fail_count <= fail_count + 1;
        end else begin
          want = pending_bytes.pop_front();
          if (out_read_data !== want) begin
            $error("read_data mismatch: expected %02h, actual %02h", want, out_read_data);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        case (op_t'(in_operation))
          OP_PLOT: begin
            side = (in_scale > MAX_SCALE) ? int'(MAX_SCALE) : int'(in_scale);
            paint_square(in_x, in_y, side, in_color);
          end
          OP_CLEAR: foreach (shadow_pixels[i]) shadow_pixels[i] = BYTE_CLEAR;
          OP_FILL:  foreach (shadow_pixels[i]) shadow_pixels[i] = BYTE_FILL;
          default: begin
            if (in_read_index < STORE_BYTES) pending_bytes.push_back(shadow_pixels[in_read_index]);
            else pending_bytes.push_back(BYTE_CLEAR);
          end
        endcase
      end
      pending <= pending_bytes.size();
    end
  end

endmodule

FILE: dv/tb_paged_mono_framebuffer_plotter.sv
`timescale 1ns / 1ps
// tb_paged_mono_framebuffer_plotter: directed then random command words into the
// plotter with random gaps and result stalls; depends on pmfb_pkg, pmfb_checker, rtl
module tb_paged_mono_framebuffer_plotter;
  import pmfb_pkg::*;

  localparam int unsigned PANEL_WIDTH  = 128;
  localparam int unsigned PANEL_HEIGHT = 64;
  localparam int unsigned MAX_SCALE    = 16;
  localparam int RANDOM_WORDS   = 650;
  localparam int IDLE_PCT       = 28;
  localparam int QUIET_FIRST    = 250;
  localparam int QUIET_LAST     = 380;
  localparam int WATCHDOG_LIMIT = 10000;
  localparam int TAIL_CYCLES    = 1200;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        in_operation;
  logic signed [8:0] in_x;
  logic signed [8:0] in_y;
  logic              in_color;
  logic [4:0]        in_scale;
  logic [9:0]        in_read_index;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [7:0]        out_read_data;

  bit quiet = 1'b0;
  int fail_count;
  int pending;
  int idle_cycles = 0;
  int last_col = 0;
  int last_row = 0;
  int last_side = 1;

  paged_mono_framebuffer_plotter #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .PANEL_HEIGHT(PANEL_HEIGHT),
    .MAX_SCALE   (MAX_SCALE)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_x         (in_x),
    .in_y         (in_y),
    .in_color     (in_color),
    .in_scale     (in_scale),
    .in_read_index(in_read_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_read_data(out_read_data)
  );

  pmfb_checker #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .PANEL_HEIGHT(PANEL_HEIGHT),
    .MAX_SCALE   (MAX_SCALE)
  ) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_x         (in_x),
    .in_y         (in_y),
    .in_color     (in_color),
    .in_scale     (in_scale),
    .in_read_index(in_read_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_read_data(out_read_data),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("paged_mono_framebuffer_plotter regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_word(op_t op, int col, int row, bit color, int side, int index);
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_x          <= 9'(col);
    in_y          <= 9'(row);
    in_color      <= color;
    in_scale      <= 5'(side);
    in_read_index <= 10'(index);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_operation  <= OP_PLOT;
    in_x          <= '0;
    in_y          <= '0;
    in_color      <= 1'b0;
    in_scale      <= '0;
    in_read_index <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners
    send_word(OP_READ, 0, 0, 1'b0, 0, 0);
    send_word(OP_PLOT, 0, 0, 1'b1, 1, 0);
    send_word(OP_READ, 0, 0, 1'b0, 0, 0);
    send_word(OP_PLOT, 127, 63, 1'b1, 1, 0);
    send_word(OP_READ, 0, 0, 1'b0, 0, 1023);
    send_word(OP_PLOT, -1, 0, 1'b1, 1, 0);
    send_word(OP_PLOT, 128, 0, 1'b1, 1, 0);
    send_word(OP_PLOT, 0, 64, 1'b1, 1, 0);
    send_word(OP_PLOT, 255, 255, 1'b1, 1, 0);
    send_word(OP_PLOT, -256, -256, 1'b1, 16, 0);
    send_word(OP_PLOT, 5, 5, 1'b1, 0, 0);
    send_word(OP_READ, 0, 0, 1'b0, 0, 5 + 0 * PANEL_WIDTH);
    send_word(OP_PLOT, 1, 0, 1'b1, 31, 0);
    send_word(OP_READ, 0, 0, 1'b0, 0, 16);
    send_word(OP_READ, 0, 0, 1'b0, 0, PANEL_WIDTH + 31);
    send_word(OP_PLOT, 42, 21, 1'b1, 3, 1023);
    send_word(OP_READ, 0, 0, 1'b0, 0, 126 + 7 * PANEL_WIDTH);
    send_word(OP_PLOT, 0, 0, 1'b0, 1, 0);
    send_word(OP_READ, 0, 0, 1'b0, 0, 0);
    send_word(OP_FILL, 0, 0, 1'b0, 0, 0);
    send_word(OP_READ, 0, 0, 1'b0, 0, 500);
    send_word(OP_PLOT, 3, 9, 1'b0, 1, 0);
    send_word(OP_READ, 0, 0, 1'b0, 0, 3 + PANEL_WIDTH);
    send_word(OP_CLEAR, 0, 0, 1'b0, 0, 0);
    send_word(OP_READ, 0, 0, 1'b0, 0, 1023);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      int pick;
      int mix;
      int side;
      int eff;
      int col;
      int row;
      int rcol;
      int rrow;
      int index;
      quiet <= (n >= QUIET_FIRST && n < QUIET_LAST);
      pick = $urandom_range(99);
      if (pick < 2) begin
        send_word(OP_CLEAR, int'($urandom_range(511)) - 256, int'($urandom_range(511)) - 256,
                  $urandom_range(1), $urandom_range(31), $urandom_range(1023));
      end else if (pick < 4) begin
        send_word(OP_FILL, int'($urandom_range(511)) - 256, int'($urandom_range(511)) - 256,
                  $urandom_range(1), $urandom_range(31), $urandom_range(1023));
      end else if (pick < 50) begin
        mix = $urandom_range(99);
        if (mix < 60) side = $urandom_range(4, 1);
        else if (mix < 90) side = $urandom_range(16, 5);
        else if (mix < 95) side = $urandom_range(31, 17);
        else side = 0;
        eff = (side == 0) ? 1 : ((side > int'(MAX_SCALE)) ? int'(MAX_SCALE) : side);
        col = int'($urandom_range(PANEL_WIDTH / eff + 1)) - 1;
        row = int'($urandom_range(PANEL_HEIGHT / eff + 1)) - 1;
        last_col  = col * eff;
        last_row  = row * eff;
        last_side = eff;
        send_word(OP_PLOT, col, row, $urandom_range(1), side, $urandom_range(1023));
      end else if (pick < 88) begin
        if ($urandom_range(1) == 1) begin
          rcol = last_col + int'($urandom_range(last_side - 1));
          rrow = last_row + int'($urandom_range(last_side - 1));
          rcol = (rcol < 0) ? 0 : ((rcol >= int'(PANEL_WIDTH)) ? int'(PANEL_WIDTH) - 1 : rcol);
          rrow = (rrow < 0) ? 0 : ((rrow >= int'(PANEL_HEIGHT)) ? int'(PANEL_HEIGHT) - 1 : rrow);
          index = rcol + (rrow / int'(ROWS_PER_PAGE)) * int'(PANEL_WIDTH);
        end else begin
          index = $urandom_range(1023);
        end
        send_word(OP_READ, int'($urandom_range(511)) - 256, int'($urandom_range(511)) - 256,
                  $urandom_range(1), $urandom_range(31), index);
      end else begin
        send_word(op_t'($urandom_range(3)), int'($urandom_range(511)) - 256,
                  int'($urandom_range(511)) - 256, $urandom_range(1), $urandom_range(31),
                  $urandom_range(1023));
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("paged_mono_framebuffer_plotter regression: pass");
    end else begin
      $display("paged_mono_framebuffer_plotter regression: fail");
    end
    $finish;
  end

endmodule
